### rtl/core/bfpp_pkg.sv
// bfpp_pkg: widths, register codes and shared types of the pixel plotter
// no dependencies; compiled first

package bfpp_pkg;

    localparam int COORD_W    = 16;
    localparam int COLOUR_W   = 24;
    localparam int BYTE_W     = 8;
    localparam int DIM_W      = 13;
    localparam int PITCH_W    = 16;
    localparam int SHIFT_W    = 5;
    localparam int KB_W       = 7;
    localparam int BANK_W     = 8;
    localparam int OFFSET_W   = 28;
    localparam int WORD_W     = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // 256 words per kilobyte window
    localparam int WIN_LSB   = 8;
    localparam int QUOT_W    = OFFSET_W - WIN_LSB;
    localparam int DIV_STEPS = QUOT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BANK_W-1:0] BANK_ALL_ONES = {BANK_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_LINE_PITCH    = 3'd2,
        REG_RED_SHIFT     = 3'd3,
        REG_GREEN_SHIFT   = 3'd4,
        REG_BLUE_SHIFT    = 3'd5,
        REG_LINEAR_MODE   = 3'd6,
        REG_WINDOW_KBYTES = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0]   screen_width;
        logic [DIM_W-1:0]   screen_height;
        logic [PITCH_W-1:0] line_pitch_bytes;
        logic [SHIFT_W-1:0] red_shift;
        logic [SHIFT_W-1:0] green_shift;
        logic [SHIFT_W-1:0] blue_shift;
        logic               linear_mode;
        logic [KB_W-1:0]    window_kbytes;
    } cfg_t;

    typedef struct packed {
        logic                drawn;
        logic [OFFSET_W-1:0] offset;
        logic [WORD_W-1:0]   pixel;
    } job_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } qstat_t;

    function automatic logic [WORD_W-1:0] place_byte(input logic [BYTE_W-1:0] b,
                                                     input logic [SHIFT_W-1:0] sh);
        logic [WORD_W-1:0] wide;
        wide = WORD_W'(b);
        return wide << sh;
    endfunction

endpackage

### rtl/core/bfpp_if.sv
// bfpp_pixel_if and bfpp_write_if: request channels of the pixel plotter
// depends on bfpp_pkg

interface bfpp_pixel_if;
    import bfpp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  pixel_x;
    logic signed [COORD_W-1:0]  pixel_y;
    logic        [COLOUR_W-1:0] rgb_colour;

    modport source (output valid, pixel_x, pixel_y, rgb_colour, input ready);
    modport sink   (input valid, pixel_x, pixel_y, rgb_colour, output ready);
endinterface

interface bfpp_write_if;
    import bfpp_pkg::*;

    logic                valid;
    logic                ready;
    logic                drawn;
    logic                bank_switch;
    logic [BANK_W-1:0]   bank_sel;
    logic [OFFSET_W-1:0] word_offset;
    logic [WORD_W-1:0]   pixel_word;

    modport source (output valid, drawn, bank_switch, bank_sel, word_offset, pixel_word,
                    input ready);
    modport sink   (input valid, drawn, bank_switch, bank_sel, word_offset, pixel_word,
                    output ready);
endinterface

### rtl/core/banked_framebuffer_pixel_plotter.sv
// banked_framebuffer_pixel_plotter: top level with configuration registers
// depends on bfpp_pkg, bfpp_if, bfpp_front, bfpp_queue and bfpp_back
//
// Each pixel request gives one framebuffer write request. The front end takes a
// request every cycle while its two-entry queue has room, clips it against the
// screen and forms the word offset and packed colour. The back end takes one
// queued request at a time: clipped, linear-mode and zero-window requests go
// from pop straight to the result state, other banked-mode requests pass
// through 20 steps of a restoring divider by window size between the two.
// A finished write waits in the output register while the next request is
// taken; that request then waits in the result state until the register is free.
// Configuration is written through write_enable, write_index and write_data.

module banked_framebuffer_pixel_plotter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 write_enable,
    input  logic [bfpp_pkg::CFG_IDX_W-1:0]       write_index,
    input  logic [bfpp_pkg::CFG_DATA_W-1:0]      write_data,
    bfpp_pixel_if.sink                           pixel_in,
    bfpp_write_if.source                         write_out
);
    import bfpp_pkg::*;

    cfg_t   cfg_reg;
    logic   push;
    logic   pop;
    job_t   push_job;
    job_t   head;
    qstat_t qstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width     <= DIM_W'(640);
            cfg_reg.screen_height    <= DIM_W'(480);
            cfg_reg.line_pitch_bytes <= PITCH_W'(2560);
            cfg_reg.red_shift        <= SHIFT_W'(16);
            cfg_reg.green_shift      <= SHIFT_W'(8);
            cfg_reg.blue_shift       <= SHIFT_W'(0);
            cfg_reg.linear_mode      <= 1'b1;
            cfg_reg.window_kbytes    <= KB_W'(64);
        end
        else if (write_enable)
        begin
            case (cfg_idx_t'(write_index))
                REG_SCREEN_WIDTH:  cfg_reg.screen_width     <= write_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height    <= write_data[DIM_W-1:0];
                REG_LINE_PITCH:    cfg_reg.line_pitch_bytes <= write_data[PITCH_W-1:0];
                REG_RED_SHIFT:     cfg_reg.red_shift        <= write_data[SHIFT_W-1:0];
                REG_GREEN_SHIFT:   cfg_reg.green_shift      <= write_data[SHIFT_W-1:0];
                REG_BLUE_SHIFT:    cfg_reg.blue_shift       <= write_data[SHIFT_W-1:0];
                REG_LINEAR_MODE:   cfg_reg.linear_mode      <= write_data[0];
                REG_WINDOW_KBYTES: cfg_reg.window_kbytes    <= write_data[KB_W-1:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    bfpp_front u_front (
        .pixel_in (pixel_in),
        .cfg      (cfg_reg),
        .qstat    (qstat),
        .push     (push),
        .job      (push_job)
    );

    bfpp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    bfpp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .qstat     (qstat),
        .head      (head),
        .pop       (pop),
        .write_out (write_out)
    );

endmodule

### rtl/core/bfpp_front.sv
// bfpp_front: accepts pixel requests, clips, forms word offset and packed colour
// depends on bfpp_pkg and bfpp_if

module bfpp_front (
    bfpp_pixel_if.sink       pixel_in,
    input  bfpp_pkg::cfg_t   cfg,
    input  bfpp_pkg::qstat_t qstat,
    output logic             push,
    output bfpp_pkg::job_t   job
);
    import bfpp_pkg::*;

    logic [COORD_W-1:0]           x_u;
    logic [COORD_W-1:0]           y_u;
    logic                         off_screen;
    logic [PITCH_W-3:0]           words_per_line;
    logic [DIM_W+PITCH_W-3:0]     row_base;
    logic [OFFSET_W-1:0]          offset;
    logic [WORD_W-1:0]            pixel;

    assign x_u = pixel_in.pixel_x;
    assign y_u = pixel_in.pixel_y;

    assign off_screen = x_u[COORD_W-1] || y_u[COORD_W-1]
        || (x_u >= {{(COORD_W-DIM_W){1'b0}}, cfg.screen_width})
        || (y_u >= {{(COORD_W-DIM_W){1'b0}}, cfg.screen_height});

    assign words_per_line = cfg.line_pitch_bytes[PITCH_W-1:2];
    assign row_base       = y_u[DIM_W-1:0] * words_per_line;
    assign offset         = OFFSET_W'(row_base) + OFFSET_W'(x_u[DIM_W-1:0]);

    assign pixel = place_byte(pixel_in.rgb_colour[3*BYTE_W-1:2*BYTE_W], cfg.red_shift)
                 | place_byte(pixel_in.rgb_colour[2*BYTE_W-1:BYTE_W], cfg.green_shift)
                 | place_byte(pixel_in.rgb_colour[BYTE_W-1:0], cfg.blue_shift);

    assign pixel_in.ready = qstat.not_full;
    assign push           = pixel_in.valid && qstat.not_full;

    always_comb
    begin
        if (off_screen)
        begin
            job = '0;
        end
        else
        begin
            job.drawn  = 1'b1;
            job.offset = offset;
            job.pixel  = pixel;
        end
    end

endmodule

### rtl/core/bfpp_queue.sv
// bfpp_queue: short request queue between front and back
// depends on bfpp_pkg

module bfpp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bfpp_pkg::job_t   push_job,
    input  logic             pop,
    output bfpp_pkg::job_t   head,
    output bfpp_pkg::qstat_t qstat
);
    import bfpp_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;

    assign wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head            = mem_reg[rd_ptr_reg];
    assign qstat.not_empty = (count_reg != '0);
    assign qstat.not_full  = (count_reg != QCNT_W'(QUEUE_DEPTH));

endmodule

### rtl/core/bfpp_back.sv
// bfpp_back: bank split by iterative divider, bank tracking, output register
// depends on bfpp_pkg and bfpp_if

module bfpp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  bfpp_pkg::cfg_t   cfg,
    input  bfpp_pkg::qstat_t qstat,
    input  bfpp_pkg::job_t   head,
    output logic             pop,
    bfpp_write_if.source     write_out
);
    import bfpp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } state_t;

    state_t              state_reg;
    job_t                job_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic [KB_W-1:0]     rem_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [BANK_W-1:0]   current_bank_reg;
    logic                out_valid_reg;
    logic                out_drawn_reg;
    logic                out_switch_reg;
    logic [BANK_W-1:0]   out_bank_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [WORD_W-1:0]   out_pixel_reg;

    logic                head_needs_div;
    logic [KB_W:0]       trial;
    logic [KB_W:0]       divisor;
    logic [KB_W:0]       diff;
    logic                quot_bit;
    logic [KB_W-1:0]     rem_step;
    logic                banked;
    logic [BANK_W-1:0]   res_bank;
    logic [OFFSET_W-1:0] res_offset;
    logic                res_switch;
    logic                out_free;

    assign head_needs_div = head.drawn && !cfg.linear_mode && (cfg.window_kbytes != '0);
    assign pop            = (state_reg == S_IDLE) && qstat.not_empty;

    // one restoring step: shift in the next dividend bit, subtract when it fits
    assign trial    = {rem_reg, quot_reg[QUOT_W-1]};
    assign divisor  = {1'b0, cfg.window_kbytes};
    assign diff     = trial - divisor;
    assign quot_bit = (trial >= divisor);
    assign rem_step = quot_bit ? diff[KB_W-1:0] : trial[KB_W-1:0];

    assign banked = job_reg.drawn && !cfg.linear_mode;

    always_comb
    begin
        res_bank   = '0;
        res_offset = job_reg.offset;
        if (banked)
        begin
            if (cfg.window_kbytes == '0)
            begin
                res_bank = BANK_ALL_ONES;
            end
            else
            begin
                res_bank   = quot_reg[BANK_W-1:0];
                res_offset = {{(QUOT_W-KB_W){1'b0}}, rem_reg, job_reg.offset[WIN_LSB-1:0]};
            end
        end
    end

    assign res_switch = banked && (res_bank != current_bank_reg);
    assign out_free   = !out_valid_reg || write_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            job_reg          <= '0;
            quot_reg         <= '0;
            rem_reg          <= '0;
            step_reg         <= '0;
            current_bank_reg <= '0;
            out_valid_reg    <= 1'b0;
            out_drawn_reg    <= 1'b0;
            out_switch_reg   <= 1'b0;
            out_bank_reg     <= '0;
            out_offset_reg   <= '0;
            out_pixel_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && write_out.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        job_reg   <= head;
                        quot_reg  <= head.offset[OFFSET_W-1:WIN_LSB];
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= head_needs_div ? S_DIV : S_DONE;
                    end
                end
                S_DIV:
                begin
                    quot_reg <= {quot_reg[QUOT_W-2:0], quot_bit};
                    rem_reg  <= rem_step;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_drawn_reg  <= job_reg.drawn;
                        out_switch_reg <= res_switch;
                        out_bank_reg   <= res_bank;
                        out_offset_reg <= res_offset;
                        out_pixel_reg  <= job_reg.pixel;
                        if (res_switch)
                        begin
                            current_bank_reg <= res_bank;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign write_out.valid       = out_valid_reg;
    assign write_out.drawn       = out_drawn_reg;
    assign write_out.bank_switch = out_switch_reg;
    assign write_out.bank_sel    = out_bank_reg;
    assign write_out.word_offset = out_offset_reg;
    assign write_out.pixel_word  = out_pixel_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (step_reg <= STEP_W'(DIV_STEPS - 1)))
        else $error("divider step count out of range");

    a_clipped_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_drawn_reg) |->
            (!out_switch_reg && out_bank_reg == '0 && out_offset_reg == '0
             && out_pixel_reg == '0))
        else $error("clipped request carries a payload");

    a_switch_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_switch_reg) |-> (out_bank_reg == current_bank_reg))
        else $error("bank switch not reflected in current bank");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !pop)
        else $error("queue popped while back end busy");

endmodule
